// File: rtl/paa_pkg.sv
// paa_pkg: shared widths, register indexes and field constants for the
// piecewise aggregate approximation block. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package paa_pkg;

    // configuration port
    localparam int CFG_W     = 13;   // width of series_length and segment_count
    localparam int CFG_IDX_W = 2;    // register index width

    localparam logic [CFG_IDX_W-1:0] REG_SERIES_LENGTH = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SEGMENT_COUNT = 2'd1;

    localparam logic [CFG_W-1:0] RESET_SERIES_LENGTH = 13'd4096;
    localparam logic [CFG_W-1:0] RESET_SEGMENT_COUNT = 13'd1;

    // result fields
    localparam int MEAN_W      = 24;  // signed Q8.16
    localparam int IDX_W       = 12;
    localparam int FRAC_SHIFT  = 8;   // Q8.8 sample sum scaled to Q8.16
    localparam int OUT_TDATA_W = ((MEAN_W + IDX_W + 7) / 8) * 8;
    localparam int OUT_PAD_W   = OUT_TDATA_W - MEAN_W - IDX_W;

    localparam logic [MEAN_W-1:0] MEAN_POS_MAX = 24'h7FFFFF;
    localparam logic [MEAN_W-1:0] MEAN_NEG_MAX = 24'h800000;  // magnitude of most negative

endpackage

`default_nettype wire

// File: rtl/paa_div.sv
// paa_div: restoring divider, one quotient bit per cycle, that turns a
// weighted segment sum into a rounded, saturated Q8.16 mean. Uses paa_pkg.
`timescale 1ns / 1ps
`default_nettype none

module paa_div #(
    parameter int SUM_W = 30,
    parameter int QW    = 24,
    parameter int LEN_W = 13
) (
    input  wire                            i_clk,
    input  wire                            i_rst_n,
    input  wire                            i_start,
    input  wire  signed [SUM_W-1:0]        i_sum,
    input  wire         [LEN_W-1:0]        i_len,
    output logic                           o_done,
    output logic        [paa_pkg::MEAN_W-1:0] o_mean
);
    import paa_pkg::*;

    localparam int DW     = SUM_W + FRAC_SHIFT;
    localparam int STEP_W = $clog2(QW + 1);
    localparam int EW     = (QW > MEAN_W + 1) ? QW : MEAN_W + 1;

    logic              r_busy, n_busy;
    logic [STEP_W-1:0] r_step, n_step;
    logic [LEN_W-1:0]  r_rem,  n_rem;
    logic [QW-1:0]     r_quo,  n_quo;
    logic [LEN_W-1:0]  r_len,  n_len;
    logic              r_neg,  n_neg;

    logic [SUM_W-1:0]  w_mag;
    logic [DW-1:0]     w_dvd;
    logic [LEN_W:0]    w_trial;
    logic [LEN_W+1:0]  w_diff;
    logic              w_ge;
    logic [EW-1:0]     w_qe;

    always_comb begin
        w_mag   = i_sum[SUM_W-1] ? SUM_W'(-i_sum) : SUM_W'(i_sum);
        w_dvd   = DW'({w_mag, {FRAC_SHIFT{1'b0}}}) + DW'(i_len >> 1);
        w_trial = {r_rem, r_quo[QW-1]};
        w_diff  = {1'b0, w_trial} - {2'b00, r_len};
        w_ge    = !w_diff[LEN_W+1];
        o_done  = r_busy && (r_step == '0);
    end

    always_comb begin
        n_busy = r_busy;
        n_step = r_step;
        n_rem  = r_rem;
        n_quo  = r_quo;
        n_len  = r_len;
        n_neg  = r_neg;
        if (i_start) begin
            n_busy = 1'b1;
            n_step = STEP_W'(QW);
            // top part of the dividend is below the divisor by construction
            n_rem  = w_dvd[QW+LEN_W-1:QW];
            n_quo  = w_dvd[QW-1:0];
            n_len  = i_len;
            n_neg  = i_sum[SUM_W-1];
        end else if (r_busy) begin
            if (r_step == '0) begin
                n_busy = 1'b0;
            end else begin
                n_step = r_step - STEP_W'(1);
                n_rem  = w_ge ? w_diff[LEN_W-1:0] : w_trial[LEN_W-1:0];
                n_quo  = {r_quo[QW-2:0], w_ge};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_step <= '0;
        end else begin
            r_busy <= n_busy;
            r_step <= n_step;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rem <= n_rem;
        r_quo <= n_quo;
        r_len <= n_len;
        r_neg <= n_neg;
    end

    // saturate the magnitude and apply the sign
    always_comb begin
        w_qe = EW'(r_quo);
        if (r_neg) begin
            if (w_qe > EW'(MEAN_NEG_MAX)) o_mean = MEAN_NEG_MAX;
            else                          o_mean = -w_qe[MEAN_W-1:0];
        end else begin
            if (w_qe > EW'(MEAN_POS_MAX)) o_mean = MEAN_POS_MAX;
            else                          o_mean = w_qe[MEAN_W-1:0];
        end
    end

endmodule

`default_nettype wire

// File: rtl/piecewise_aggregate_approximation.sv
// piecewise_aggregate_approximation: top level with configuration registers,
// the sequencer, one shared multiplier and the output register. Uses paa_pkg, paa_div.
//
//  channel   dir  handshake                      payload
//  s_axis    in   s_axis_tvalid / s_axis_tready  tdata: sample
//  m_axis    out  m_axis_tvalid / m_axis_tready  tdata: segment_mean, segment_index; tlast
//  cfg       in   i_cfg_valid / o_cfg_ready      i_cfg_index, i_cfg_data
//
// an item that closes no segment passes S_MUL1 and S_ACC1; one that closes a segment
// then waits in S_DIV for the bit-serial divider, then S_LOAD and, unless last, S_MUL2
// reset: series_length 4096, segment_count 1, sum, position and segment cleared
// a stalled output holds the sequencer before its output load; cfg is always ready
// a write to either register restarts the series
`timescale 1ns / 1ps
`default_nettype none

module piecewise_aggregate_approximation #(
    parameter int MAX_LENGTH   = 4096,
    parameter int SAMPLE_WIDTH = 16
) (
    input  wire                                   i_clk,
    input  wire                                   i_rst_n,
    // sample item
    input  wire                                   s_axis_tvalid,
    output logic                                  s_axis_tready,
    input  wire  [((SAMPLE_WIDTH+7)/8)*8-1:0]     s_axis_tdata,   // [SAMPLE_WIDTH-1:0] sample
    // segment item
    output logic                                  m_axis_tvalid,
    input  wire                                   m_axis_tready,
    output logic [paa_pkg::OUT_TDATA_W-1:0]       m_axis_tdata,   // [23:0] segment_mean,
                                                                  // [35:24] segment_index
    output logic                                  m_axis_tlast,   // last_segment
    // configuration writes
    input  wire                                   i_cfg_valid,
    output logic                                  o_cfg_ready,
    input  wire  [paa_pkg::CFG_IDX_W-1:0]         i_cfg_index,
    input  wire  [paa_pkg::CFG_W-1:0]             i_cfg_data
);
    import paa_pkg::*;

    localparam int SUM_W = SAMPLE_WIDTH + CFG_W + 1;
    localparam int POS_W = 2 * CFG_W + 1;
    localparam int QW    = SAMPLE_WIDTH + FRAC_SHIFT;

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_MUL1 = 6'b000010,
        S_ACC1 = 6'b000100,
        S_DIV  = 6'b001000,
        S_LOAD = 6'b010000,
        S_MUL2 = 6'b100000
    } t_state;

    function automatic logic [CFG_W-1:0] eff_len(input logic [CFG_W-1:0] v);
        logic [CFG_W-1:0] l;
        l = v;
        if (l == '0) l = CFG_W'(1);
        if (32'(l) > MAX_LENGTH) l = CFG_W'(MAX_LENGTH);
        return l;
    endfunction

    function automatic logic [CFG_W-1:0] eff_cnt(input logic [CFG_W-1:0] c,
                                                 input logic [CFG_W-1:0] l);
        logic [CFG_W-1:0] k;
        k = c;
        if (k == '0) k = CFG_W'(1);
        if (k > l) k = l;
        return k;
    endfunction

    // control state
    t_state                    r_state,  n_state;
    logic [CFG_W-1:0]          r_series, n_series;
    logic [CFG_W-1:0]          r_count,  n_count;
    logic [CFG_W-1:0]          r_len,    n_len;
    logic [CFG_W-1:0]          r_cnt,    n_cnt;
    logic signed [SUM_W-1:0]   r_sum,    n_sum;
    logic [CFG_W-1:0]          r_pos,    n_pos;
    logic [CFG_W-1:0]          r_seg,    n_seg;
    logic [POS_W-1:0]          r_start,  n_start;
    logic [POS_W-1:0]          r_nb,     n_nb;
    logic                      r_out_valid, n_out_valid;
    // payload
    logic signed [SAMPLE_WIDTH-1:0] r_sample, n_sample;
    logic signed [SUM_W-1:0]   r_prod,   n_prod;
    logic                      r_hit,    n_hit;
    logic [MEAN_W-1:0]         r_out_mean,  n_out_mean;
    logic [IDX_W-1:0]          r_out_index, n_out_index;
    logic                      r_out_last,  n_out_last;

    logic                      w_s_acc, w_cfg_we, w_cfg_known;
    logic [POS_W-1:0]          w_end;
    logic [CFG_W-1:0]          w_ov;
    logic signed [SUM_W-1:0]   w_prod;
    logic signed [SUM_W-1:0]   w_acc;
    logic                      w_last;
    logic                      w_div_start, w_div_done;
    logic [MEAN_W-1:0]         w_div_mean;

    assign s_axis_tready = (r_state == S_IDLE);
    assign o_cfg_ready   = 1'b1;
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {{OUT_PAD_W{1'b0}}, r_out_index, r_out_mean};
    assign m_axis_tlast  = r_out_last;

    assign w_s_acc     = s_axis_tvalid && s_axis_tready;
    assign w_cfg_we    = i_cfg_valid && o_cfg_ready;
    assign w_cfg_known = (i_cfg_index == REG_SERIES_LENGTH) ||
                         (i_cfg_index == REG_SEGMENT_COUNT);

    // overlap of the current sample with the open segment, or with the next one
    always_comb begin
        w_end = r_start + POS_W'(r_cnt);
        if (r_state == S_MUL2) w_ov = CFG_W'(w_end - r_nb);
        else if (r_hit)        w_ov = CFG_W'(r_nb - r_start);
        else                   w_ov = r_cnt;
        w_prod = SUM_W'(r_sample) * SUM_W'($signed({1'b0, w_ov}));
        w_acc  = r_sum + r_prod;
        w_last = ((CFG_W+1)'(r_seg) + (CFG_W+1)'(1) >= (CFG_W+1)'(r_cnt)) ||
                 ((CFG_W+1)'(r_pos) + (CFG_W+1)'(1) >= (CFG_W+1)'(r_len));
    end

    always_comb begin
        n_state     = r_state;
        n_series    = r_series;
        n_count     = r_count;
        n_sum       = r_sum;
        n_pos       = r_pos;
        n_seg       = r_seg;
        n_start     = r_start;
        n_nb        = r_nb;
        n_out_valid = r_out_valid;
        n_sample    = r_sample;
        n_prod      = r_prod;
        n_hit       = r_hit;
        n_out_mean  = r_out_mean;
        n_out_index = r_out_index;
        n_out_last  = r_out_last;
        w_div_start = 1'b0;

        if (w_cfg_we && i_cfg_index == REG_SERIES_LENGTH) n_series = i_cfg_data;
        if (w_cfg_we && i_cfg_index == REG_SEGMENT_COUNT) n_count  = i_cfg_data;
        n_len = eff_len(n_series);
        n_cnt = eff_cnt(n_count, n_len);

        if (r_out_valid && m_axis_tready) n_out_valid = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                if (w_s_acc) begin
                    n_sample = s_axis_tdata[SAMPLE_WIDTH-1:0];
                    n_hit    = !(w_end < r_nb);
                    n_state  = S_MUL1;
                end
            end
            S_MUL1: begin
                n_prod  = w_prod;
                n_state = S_ACC1;
            end
            S_ACC1: begin
                n_sum = w_acc;
                if (r_hit) begin
                    w_div_start = 1'b1;
                    n_state     = S_DIV;
                end else begin
                    n_pos   = r_pos + CFG_W'(1);
                    n_start = w_end;
                    n_state = S_IDLE;
                end
            end
            S_DIV: begin
                if (w_div_done) n_state = S_LOAD;
            end
            S_LOAD: begin
                if (!r_out_valid || m_axis_tready) begin
                    n_out_valid = 1'b1;
                    n_out_mean  = w_div_mean;
                    n_out_index = r_seg[IDX_W-1:0];
                    n_out_last  = w_last;
                    if (w_last) begin
                        n_sum   = '0;
                        n_pos   = '0;
                        n_seg   = '0;
                        n_start = '0;
                        n_nb    = POS_W'(r_len);
                        n_state = S_IDLE;
                    end else begin
                        n_state = S_MUL2;
                    end
                end
            end
            S_MUL2: begin
                // carry-over of the sample into the next segment
                n_sum   = w_prod;
                n_seg   = r_seg + CFG_W'(1);
                n_nb    = r_nb + POS_W'(r_len);
                n_pos   = r_pos + CFG_W'(1);
                n_start = w_end;
                n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase

        if (w_cfg_we && w_cfg_known) begin
            n_sum   = '0;
            n_pos   = '0;
            n_seg   = '0;
            n_start = '0;
            n_nb    = POS_W'(n_len);
            n_state = S_IDLE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_series    <= RESET_SERIES_LENGTH;
            r_count     <= RESET_SEGMENT_COUNT;
            r_len       <= eff_len(RESET_SERIES_LENGTH);
            r_cnt       <= eff_cnt(RESET_SEGMENT_COUNT, eff_len(RESET_SERIES_LENGTH));
            r_sum       <= '0;
            r_pos       <= '0;
            r_seg       <= '0;
            r_start     <= '0;
            r_nb        <= POS_W'(eff_len(RESET_SERIES_LENGTH));
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_series    <= n_series;
            r_count     <= n_count;
            r_len       <= n_len;
            r_cnt       <= n_cnt;
            r_sum       <= n_sum;
            r_pos       <= n_pos;
            r_seg       <= n_seg;
            r_start     <= n_start;
            r_nb        <= n_nb;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_sample    <= n_sample;
        r_prod      <= n_prod;
        r_hit       <= n_hit;
        r_out_mean  <= n_out_mean;
        r_out_index <= n_out_index;
        r_out_last  <= n_out_last;
    end

    paa_div #(
        .SUM_W (SUM_W),
        .QW    (QW),
        .LEN_W (CFG_W)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_sum   (w_acc),
        .i_len   (r_len),
        .o_done  (w_div_done),
        .o_mean  (w_div_mean)
    );

    // a register write restarts the series
    a_cfg_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_cfg_we && w_cfg_known) |=> (r_pos == '0 && r_seg == '0 && r_sum == '0))
        else $error("series not restarted after register write");

    // between items the position stays inside the series
    a_pos_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> (r_pos < r_len))
        else $error("sample position beyond series length");

    // the open segment boundary always lies ahead of the next sample start
    a_boundary_ahead: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> (r_nb > r_start))
        else $error("segment boundary behind sample start");

    // segment number stays below the effective segment count
    a_seg_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> (r_seg < r_cnt))
        else $error("segment number beyond segment count");

endmodule

`default_nettype wire

// File: dv/piecewise_aggregate_approximation_checker.sv
// piecewise_aggregate_approximation_checker: watches the sample, segment and
// register write channels, predicts each segment item and compares it field by
// field. Depends on paa_pkg.
`timescale 1ns / 1ps

module piecewise_aggregate_approximation_checker #(
    parameter int MAX_LENGTH = 4096,
    parameter int SAMPLE_W   = 16
) (
    input  wire                                i_clk,
    input  wire                                i_rst_n,
    input  wire                                i_s_tvalid,
    input  wire                                i_s_tready,
    input  wire  [((SAMPLE_W+7)/8)*8-1:0]      i_s_tdata,
    input  wire                                i_m_tvalid,
    input  wire                                i_m_tready,
    input  wire  [paa_pkg::OUT_TDATA_W-1:0]    i_m_tdata,
    input  wire                                i_m_tlast,
    input  wire                                i_cfg_valid,
    input  wire                                i_cfg_ready,
    input  wire  [paa_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  wire  [paa_pkg::CFG_W-1:0]          i_cfg_data,
    output int                                 o_fail_count,
    output int                                 o_pending
);
    import paa_pkg::*;

    typedef struct packed {
        logic [MEAN_W-1:0] mean;
        logic [IDX_W-1:0]  index;
        logic              last;
    } t_segment;

    t_segment expected_segments[$];

    logic [CFG_W-1:0]  length_reg;
    logic [CFG_W-1:0]  count_reg;
    logic signed [29:0] running_sum;
    logic [CFG_W-1:0]  position;
    logic [IDX_W-1:0]  segment_no;
    logic [24:0]       boundary;

    function automatic int unsigned active_length();
        if (length_reg == 0) return 1;
        if (length_reg > MAX_LENGTH) return MAX_LENGTH;
        return length_reg;
    endfunction

    function automatic int unsigned active_count();
        int unsigned len;
        len = active_length();
        if (count_reg == 0) return 1;
        if (count_reg > len) return len;
        return count_reg;
    endfunction

    function automatic void restart_series();
        running_sum = '0;
        position    = '0;
        segment_no  = '0;
        boundary    = 25'(active_length());
    endfunction

    function automatic void apply_write(input logic [CFG_IDX_W-1:0] index,
                                        input logic [CFG_W-1:0] value);
        if (index == REG_SERIES_LENGTH) begin
            length_reg = value;
            restart_series();
        end else if (index == REG_SEGMENT_COUNT) begin
            count_reg = value;
            restart_series();
        end
    endfunction

    // sum*256/len, rounded half away from zero, clamped to 24 bits
    function automatic logic [MEAN_W-1:0] scaled_mean(input longint signed total,
                                                      input int unsigned len);
        longint unsigned mag;
        longint unsigned q;
        logic            neg;
        neg = total < 0;
        mag = neg ? longint'(-total) : total;
        mag = mag << FRAC_SHIFT;
        q   = (mag + (len >> 1)) / len;
        if (neg) begin
            if (q > MEAN_NEG_MAX) q = MEAN_NEG_MAX;
            q = -q;
        end else begin
            if (q > MEAN_POS_MAX) q = MEAN_POS_MAX;
        end
        return q[MEAN_W-1:0];
    endfunction

    // adds one sample to the open segment; queues a segment item when it closes
    function automatic void fold_sample(input logic signed [SAMPLE_W-1:0] v);
        int unsigned   len;
        int unsigned   cnt;
        int unsigned   first;
        int unsigned   stop;
        int unsigned   weight;
        int unsigned   seg_next;
        int unsigned   pos_next;
        longint signed total;
        t_segment      seg;
        len   = active_length();
        cnt   = active_count();
        first = position * cnt;
        stop  = first + cnt;
        if (stop < boundary) begin
            total       = longint'(running_sum) + longint'(v) * longint'(cnt);
            running_sum = 30'(total);
            position    = position + 1'b1;
            return;
        end
        weight    = boundary - first;
        total     = longint'(running_sum) + longint'(v) * longint'(weight);
        seg_next  = segment_no + 1;
        pos_next  = position + 1;
        seg.mean  = scaled_mean(total, len);
        seg.index = segment_no;
        seg.last  = (seg_next >= cnt) || (pos_next >= len);
        expected_segments.push_back(seg);
        if (seg.last) begin
            restart_series();
        end else begin
            weight      = stop - boundary;
            running_sum = 30'(longint'(v) * longint'(weight));
            segment_no  = segment_no + 1'b1;
            boundary    = boundary + 25'(len);
            position    = position + 1'b1;
        end
    endfunction

    task automatic report_mismatch(input string msg);
        $display("mismatch at %0t: %s", $realtime, msg);
        o_fail_count++;
    endtask

    always @(posedge i_clk) begin : watch
        t_segment want;
        if (!i_rst_n) begin
            length_reg = RESET_SERIES_LENGTH;
            count_reg  = RESET_SEGMENT_COUNT;
            restart_series();
            expected_segments.delete();
        end else begin
            if (i_m_tvalid && i_m_tready) begin
                if (expected_segments.size() == 0) begin
                    report_mismatch($sformatf("segment item with none expected, tdata %h",
                                              i_m_tdata));
                end else begin
                    want = expected_segments.pop_front();
                    if (i_m_tdata[MEAN_W-1:0] !== want.mean)
                        report_mismatch($sformatf("segment %0d mean %h, expected %h",
                                                  want.index, i_m_tdata[MEAN_W-1:0],
                                                  want.mean));
                    if (i_m_tdata[MEAN_W +: IDX_W] !== want.index)
                        report_mismatch($sformatf("segment index %0d, expected %0d",
                                                  i_m_tdata[MEAN_W +: IDX_W], want.index));
                    if (i_m_tlast !== want.last)
                        report_mismatch($sformatf("segment %0d last %b, expected %b",
                                                  want.index, i_m_tlast, want.last));
                end
            end
            if (i_cfg_valid && i_cfg_ready) apply_write(i_cfg_index, i_cfg_data);
            if (i_s_tvalid && i_s_tready) fold_sample(i_s_tdata[SAMPLE_W-1:0]);
        end
        o_pending = expected_segments.size();
    end

endmodule

// File: dv/piecewise_aggregate_approximation_tb.sv
// piecewise_aggregate_approximation_tb: clock, reset, sample and register
// stimulus with random gaps and output stalls, watchdog and verdict.
// Depends on paa_pkg, the block and piecewise_aggregate_approximation_checker.
`timescale 1ns / 1ps

module piecewise_aggregate_approximation_tb;
    import paa_pkg::*;

    localparam int PERIOD        = 20;
    localparam int SAMPLE_W      = 16;
    localparam int MAX_LEN       = 4096;
    localparam int IN_TDATA_W    = ((SAMPLE_W + 7) / 8) * 8;
    localparam int SETTLE_CYCLES = 40;
    localparam int STALL_LIMIT   = 2000;
    localparam int RANDOM_ITEMS  = 2000;
    localparam int TIE_LENGTH    = 512;

    localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 2'd3;
    localparam logic [CFG_W-1:0]     CFG_MAX     = 13'h1FFF;

    localparam logic [SAMPLE_W-1:0] SAMPLE_MAX     = 16'h7FFF;
    localparam logic [SAMPLE_W-1:0] SAMPLE_MIN     = 16'h8000;
    localparam logic [SAMPLE_W-1:0] SAMPLE_NEG_ONE = 16'hFFFF;
    localparam logic [SAMPLE_W-1:0] SAMPLE_LSB     = 16'h0001;

    logic                       i_clk = 1'b0;
    logic                       i_rst_n = 1'b0;
    logic                       s_axis_tvalid = 1'b0;
    logic                       s_axis_tready;
    logic [IN_TDATA_W-1:0]      s_axis_tdata = '0;
    logic                       m_axis_tvalid;
    logic                       m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0]     m_axis_tdata;
    logic                       m_axis_tlast;
    logic                       cfg_valid = 1'b0;
    logic                       o_cfg_ready;
    logic [CFG_IDX_W-1:0]       cfg_index = '0;
    logic [CFG_W-1:0]           cfg_data = '0;

    int fail_count;
    int pending;
    int idle_cycles = 0;
    bit hurry = 1'b0;

    always #(PERIOD / 2) i_clk = ~i_clk;

    piecewise_aggregate_approximation #(
        .MAX_LENGTH   (MAX_LEN),
        .SAMPLE_WIDTH (SAMPLE_W)
    ) uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .i_cfg_valid   (cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (cfg_index),
        .i_cfg_data    (cfg_data)
    );

    piecewise_aggregate_approximation_checker #(
        .MAX_LENGTH (MAX_LEN),
        .SAMPLE_W   (SAMPLE_W)
    ) segment_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_s_tvalid   (s_axis_tvalid),
        .i_s_tready   (s_axis_tready),
        .i_s_tdata    (s_axis_tdata),
        .i_m_tvalid   (m_axis_tvalid),
        .i_m_tready   (m_axis_tready),
        .i_m_tdata    (m_axis_tdata),
        .i_m_tlast    (m_axis_tlast),
        .i_cfg_valid  (cfg_valid),
        .i_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (cfg_index),
        .i_cfg_data   (cfg_data),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    // nothing accepted anywhere for too long means the block is stuck
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
            (cfg_valid && o_cfg_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= STALL_LIMIT) begin
                $display("FAILURE");
                $finish;
            end
        end
    end

    function automatic int draw_gap();
        return hurry ? 0 : $urandom_range(0, 17);
    endfunction

    function automatic logic [SAMPLE_W-1:0] random_sample();
        case ($urandom_range(0, 7))
            0:       return SAMPLE_MAX;
            1:       return SAMPLE_MIN;
            2:       return '0;
            3:       return SAMPLE_NEG_ONE;
            default: return SAMPLE_W'($urandom);
        endcase
    endfunction

    // returns at the falling edge after the item is taken, tvalid still high
    task automatic send_sample(input logic [SAMPLE_W-1:0] value);
        int gap;
        gap = draw_gap();
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= IN_TDATA_W'(value);
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    // leaves cfg_valid high; the caller drops it after its last write
    task automatic write_register(input logic [CFG_IDX_W-1:0] index,
                                  input logic [CFG_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data  <= value;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    // block idle: all segments out, then time for a sample still in work
    task automatic settle();
        s_axis_tvalid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic configure(input logic [CFG_W-1:0] len_val, input logic [CFG_W-1:0] cnt_val);
        settle();
        if ($urandom_range(0, 3) == 0)
            write_register($urandom_range(0, 1) ? REG_SPARE_A : REG_SPARE_B, CFG_W'($urandom));
        if ($urandom_range(0, 1)) begin
            write_register(REG_SERIES_LENGTH, len_val);
            write_register(REG_SEGMENT_COUNT, cnt_val);
        end else begin
            write_register(REG_SEGMENT_COUNT, cnt_val);
            write_register(REG_SERIES_LENGTH, len_val);
        end
        cfg_valid <= 1'b0;
    endtask

    task automatic random_phase(inout int sent);
        logic [CFG_W-1:0] len_val;
        logic [CFG_W-1:0] cnt_val;
        int               len_eff;
        int               items;
        hurry = ($urandom_range(0, 3) == 0);
        case ($urandom_range(0, 9))
            0:       len_val = $urandom_range(0, 1) ? '0 : CFG_W'($urandom_range(MAX_LEN, 8191));
            1:       len_val = CFG_W'($urandom_range(25, 200));
            default: len_val = CFG_W'($urandom_range(1, 24));
        endcase
        len_eff = (len_val == 0) ? 1 : (len_val > MAX_LEN) ? MAX_LEN : int'(len_val);
        // long series get short segments so results keep coming
        if (len_eff == MAX_LEN) begin
            cnt_val = CFG_W'($urandom_range(MAX_LEN / 2, 8191));
        end else begin
            case ($urandom_range(0, 7))
                0:       cnt_val = '0;
                1:       cnt_val = CFG_MAX;
                2:       cnt_val = len_val;
                default: cnt_val = CFG_W'($urandom_range(1, len_eff + 3));
            endcase
        end
        configure(len_val, cnt_val);
        items = len_eff * $urandom_range(1, 3);
        if ($urandom_range(0, 3) == 0) items += $urandom_range(0, len_eff - 1);
        if (items > 300) items = 300;
        repeat (items) send_sample(random_sample());
        sent += items;
    endtask

    initial begin
        int                  sent;
        logic                odd;
        logic [SAMPLE_W-1:0] v;
        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // reset settings: two samples only accumulate
        send_sample(SAMPLE_MAX);
        send_sample(random_sample());
        settle();
        // count equal to the reset length: every sample comes out unchanged
        write_register(REG_SEGMENT_COUNT, 13'd4096);
        cfg_valid <= 1'b0;
        send_sample(SAMPLE_MAX);
        send_sample(SAMPLE_MIN);
        send_sample(SAMPLE_LSB);
        send_sample(SAMPLE_NEG_ONE);
        // writes to spare indexes leave the series running
        settle();
        write_register(REG_SPARE_A, CFG_MAX);
        write_register(REG_SPARE_B, '0);
        cfg_valid <= 1'b0;
        send_sample(random_sample());
        // zero length and zero segments act as one
        configure('0, '0);
        send_sample(SAMPLE_MIN);
        send_sample(SAMPLE_MAX);
        // oversized length and count clamp to the maximum length
        configure(CFG_MAX, CFG_MAX);
        send_sample(SAMPLE_MIN);
        send_sample(SAMPLE_MAX);
        // fractional segments
        configure(13'd3, 13'd2);
        send_sample(SAMPLE_MAX);
        send_sample(SAMPLE_MAX);
        send_sample(SAMPLE_MIN);
        configure(13'd7, 13'd3);
        repeat (7) send_sample(random_sample());

        // mean of 512 samples with an odd sum lands on a half: one series of
        // each sign
        hurry = 1'b1;
        configure(13'(TIE_LENGTH), 13'd1);
        for (int k = 0; k < 2; k++) begin
            odd = 1'b0;
            for (int j = 0; j < TIE_LENGTH; j++) begin
                v = SAMPLE_W'($urandom);
                v[SAMPLE_W-1] = (k == 1);
                if (j == TIE_LENGTH - 1) v[0] = ~odd;
                odd = odd ^ v[0];
                send_sample(v);
            end
        end

        sent = 2 * TIE_LENGTH;
        while (sent < RANDOM_ITEMS) random_phase(sent);
        hurry = 1'b0;

        settle();
        if (fail_count == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

    // output side stalls a random number of cycles before each item
    initial begin
        int stall;
        @(negedge i_clk);
        forever begin
            stall = draw_gap();
            if (stall > 0) begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(negedge i_clk);
            end
            m_axis_tready <= 1'b1;
            @(posedge i_clk);
            while (!m_axis_tvalid) @(posedge i_clk);
            @(negedge i_clk);
        end
    end

endmodule

// File: files.f
rtl/paa_pkg.sv
rtl/paa_div.sv
rtl/piecewise_aggregate_approximation.sv
dv/piecewise_aggregate_approximation_checker.sv
dv/piecewise_aggregate_approximation_tb.sv
